>>> design/vurf_pkg.sv
package vurf_pkg;

    // Defaults for the top-level parameters.
    localparam int NAMETABLE_BYTES_DEF = 2048;
    localparam int DOTS_PER_LINE_DEF   = 341;
    localparam int LINES_PER_FRAME_DEF = 262;

    // The palette is fixed at 32 bytes and is indexed by the low five address bits.
    localparam int PALETTE_BYTES = 32;
    localparam int PAL_AW        = 5;

    localparam int VADDR_W = 14;
    localparam int CNT_W   = 9;

    localparam logic [CNT_W-1:0] VBLANK_LINE    = 9'd241;
    localparam logic [CNT_W-1:0] PRERENDER_LINE = 9'd261;

    localparam logic [VADDR_W-1:0] NAME_BASE    = 14'h2000;
    localparam logic [VADDR_W-1:0] NAME_LAST    = 14'h3EFF;
    localparam logic [VADDR_W-1:0] STEP_ACROSS  = 14'd32;
    localparam logic [VADDR_W-1:0] STEP_DOWN    = 14'd1;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_READ    = 2'd1,
        ACT_WRITE   = 2'd2,
        ACT_NMI_ACK = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } reg_sel_t;

    typedef enum logic [1:0] {
        SRC_PATTERN = 2'd0,
        SRC_NAME    = 2'd1,
        SRC_PALETTE = 2'd2
    } vram_src_t;

    typedef struct packed {
        action_t      action;
        logic [15:0]  cpu_addr;
        logic [7:0]   write_data;
        logic [7:0]   pattern_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         read_data;
        logic               nmi_taken;
        logic               nmi_pending;
        logic [VADDR_W-1:0] vram_access_addr;
        logic               in_vblank;
    } out_item_t;

endpackage

>>> design/vurf_in_if.sv
interface vurf_in_if
    import vurf_pkg::*;
;
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

>>> design/vurf_out_if.sv
interface vurf_out_if
    import vurf_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

>>> design/video_unit_register_file.sv
// CPU-facing register file of a tile-based video unit. Each item is a dot tick,
// a CPU read, a CPU write or an NMI acknowledge, and each item yields exactly one
// result item. The block takes one item per clock while it is not clearing and its
// skid register is empty, and delivers its result through a result register; a
// second result register lets intake continue for one more item while the sink
// stalls, and intake stops only when both hold results. The name table and the
// palette sit in two synchronous RAMs. A data read returns the read buffer and
// fetches the next buffer value from RAM; that value is forwarded straight from
// the RAM output if another data read follows at once. After reset the block
// sweeps zeros into every address of both RAMs and accepts no item during
// that sweep. Mask and OAM address writes are taken and discarded, as neither
// register has a read path or any effect on a result; a scroll write only flips
// the toggle; only control bits 2 (address step) and 7 (NMI enable) are kept.
module video_unit_register_file
    import vurf_pkg::*;
#(
    parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_DEF,
    parameter int DOTS_PER_LINE   = DOTS_PER_LINE_DEF,
    parameter int LINES_PER_FRAME = LINES_PER_FRAME_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    vurf_in_if.sink   req,
    vurf_out_if.source rsp
);
    localparam int NT_AW = $clog2(NAMETABLE_BYTES);
    localparam logic [15:0] NT_SIZE = 16'(NAMETABLE_BYTES);
    localparam logic [NT_AW-1:0] NT_LAST = NT_AW'(NAMETABLE_BYTES - 1);
    localparam logic [CNT_W-1:0] DOTS  = CNT_W'(DOTS_PER_LINE);
    localparam logic [CNT_W-1:0] LINES = CNT_W'(LINES_PER_FRAME);

    // Clearing sweep state.
    logic             clearing_reg, clearing_next;
    logic [NT_AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Architectural state.
    logic               ctrl_nmi_reg, ctrl_nmi_next;
    logic               ctrl_inc32_reg, ctrl_inc32_next;
    logic               vblank_reg, vblank_next;
    logic [7:0]         oam_byte_reg, oam_byte_next;
    logic [7:0]         read_buffer_reg, read_buffer_next;
    logic [VADDR_W-1:0] vram_reg, vram_next;
    logic [VADDR_W-1:0] temp_reg, temp_next;
    logic               toggle_reg, toggle_next;
    logic [CNT_W-1:0]   dot_reg, dot_next;
    logic [CNT_W-1:0]   line_reg, line_next;
    logic               nmi_reg, nmi_next;

    // A buffer refill in flight: the new value is taken from the RAM output.
    logic       pend_reg, pend_next;
    vram_src_t  pend_src_reg, pend_src_next;
    logic [7:0] pend_pat_reg, pend_pat_next;

    // Result register and skid register.
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_reg, out_next;
    out_item_t skid_reg, skid_next;

    logic             accept;
    logic             pop;
    logic             in_range;
    reg_sel_t         rsel;
    vram_src_t        region;
    logic [15:0]      nt_rem;
    logic [NT_AW-1:0] nt_idx;
    logic [7:0]       buf_eff;
    logic [7:0]       nt_rdata, pal_rdata;
    logic             nt_we, pal_we;
    logic [NT_AW-1:0] nt_waddr;
    logic [PAL_AW-1:0] pal_waddr;
    logic [7:0]       ram_wdata;
    logic [VADDR_W-1:0] vram_step;
    out_item_t        result;

    assign req.ready = !skid_valid_reg && !clearing_reg;
    assign accept    = req.valid && req.ready;
    assign pop       = out_valid_reg && rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_reg;

    assign in_range  = (req.item.cpu_addr[15:13] == 3'b001);
    assign rsel      = reg_sel_t'(req.item.cpu_addr[2:0]);
    assign vram_step = ctrl_inc32_reg ? STEP_ACROSS : STEP_DOWN;

    // Region of the current VRAM address.
    always_comb
    begin
        if (vram_reg < NAME_BASE)
        begin
            region = SRC_PATTERN;
        end
        else if (vram_reg <= NAME_LAST)
        begin
            region = SRC_NAME;
        end
        else
        begin
            region = SRC_PALETTE;
        end
    end

    // Name table index: the address modulo the table size. The address is below
    // sixteen times the smallest table, so four restoring steps suffice.
    always_comb
    begin
        nt_rem = {2'b00, vram_reg};
        for (int k = 3; k >= 0; k--)
        begin
            if (nt_rem >= (NT_SIZE << k))
            begin
                nt_rem = nt_rem - (NT_SIZE << k);
            end
        end
        nt_idx = nt_rem[NT_AW-1:0];
    end

    // The read buffer as the model sees it now.
    always_comb
    begin
        if (pend_reg)
        begin
            case (pend_src_reg)
                SRC_NAME:    buf_eff = nt_rdata;
                SRC_PALETTE: buf_eff = pal_rdata;
                default:     buf_eff = pend_pat_reg;
            endcase
        end
        else
        begin
            buf_eff = read_buffer_reg;
        end
    end

    always_comb
    begin
        logic [CNT_W-1:0] dot_inc;
        logic [CNT_W-1:0] line_inc;

        dot_inc          = dot_reg + 1'b1;
        line_inc         = line_reg;
        ctrl_nmi_next    = ctrl_nmi_reg;
        ctrl_inc32_next  = ctrl_inc32_reg;
        vblank_next      = vblank_reg;
        oam_byte_next    = oam_byte_reg;
        read_buffer_next = buf_eff;
        vram_next        = vram_reg;
        temp_next        = temp_reg;
        toggle_next      = toggle_reg;
        dot_next         = dot_reg;
        line_next        = line_reg;
        nmi_next         = nmi_reg;
        pend_next        = 1'b0;
        pend_src_next    = pend_src_reg;
        pend_pat_next    = pend_pat_reg;
        nt_we            = 1'b0;
        pal_we           = 1'b0;
        ram_wdata        = req.item.write_data;
        result           = '0;

        if (accept)
        begin
            case (req.item.action)
                ACT_TICK:
                begin
                    if (dot_inc >= DOTS)
                    begin
                        dot_inc  = '0;
                        line_inc = line_reg + 1'b1;
                    end
                    if (line_inc == VBLANK_LINE && dot_inc == 9'd1)
                    begin
                        vblank_next = 1'b1;
                        if (ctrl_nmi_reg)
                        begin
                            nmi_next = 1'b1;
                        end
                    end
                    if (line_inc == PRERENDER_LINE && dot_inc == 9'd1)
                    begin
                        vblank_next = 1'b0;
                    end
                    if (line_inc >= LINES)
                    begin
                        line_inc = '0;
                    end
                    dot_next  = dot_inc;
                    line_next = line_inc;
                end
                ACT_READ:
                begin
                    if (in_range)
                    begin
                        case (rsel)
                            REG_STATUS:
                            begin
                                result.read_data = {vblank_reg, 7'b0};
                                vblank_next      = 1'b0;
                                toggle_next      = 1'b0;
                            end
                            REG_OAM_DATA:
                            begin
                                result.read_data = oam_byte_reg;
                            end
                            REG_DATA:
                            begin
                                result.read_data = buf_eff;
                                pend_next        = 1'b1;
                                pend_src_next    = region;
                                pend_pat_next    = req.item.pattern_byte;
                                vram_next        = vram_reg + vram_step;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ACT_WRITE:
                begin
                    if (in_range)
                    begin
                        case (rsel)
                            REG_CTRL:
                            begin
                                ctrl_nmi_next   = req.item.write_data[7];
                                ctrl_inc32_next = req.item.write_data[2];
                            end
                            REG_OAM_DATA:
                            begin
                                oam_byte_next = req.item.write_data;
                            end
                            REG_SCROLL:
                            begin
                                toggle_next = !toggle_reg;
                            end
                            REG_ADDR:
                            begin
                                if (!toggle_reg)
                                begin
                                    temp_next = {req.item.write_data[5:0], temp_reg[7:0]};
                                end
                                else
                                begin
                                    temp_next = {temp_reg[13:8], req.item.write_data};
                                    vram_next = {temp_reg[13:8], req.item.write_data};
                                end
                                toggle_next = !toggle_reg;
                            end
                            REG_DATA:
                            begin
                                nt_we     = (region == SRC_NAME);
                                pal_we    = (region == SRC_PALETTE);
                                vram_next = vram_reg + vram_step;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ACT_NMI_ACK:
                begin
                    result.nmi_taken = nmi_reg;
                    nmi_next         = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        if (clearing_reg)
        begin
            nt_we     = 1'b1;
            pal_we    = 1'b1;
            ram_wdata = '0;
        end

        result.nmi_pending      = nmi_next;
        result.vram_access_addr = vram_next;
        result.in_vblank        = vblank_next;
    end

    assign nt_waddr  = clearing_reg ? clr_cnt_reg : nt_idx;
    assign pal_waddr = clearing_reg ? clr_cnt_reg[PAL_AW-1:0] : vram_reg[PAL_AW-1:0];

    // Clearing sweep after reset.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == NT_LAST)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    // Result register with one skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = accept;
                if (accept)
                begin
                    skid_next = result;
                end
            end
            else
            begin
                out_valid_next = accept;
                if (accept)
                begin
                    out_next = result;
                end
            end
        end
        else if (accept)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg    <= 1'b1;
            clr_cnt_reg     <= '0;
            ctrl_nmi_reg    <= 1'b0;
            ctrl_inc32_reg  <= 1'b0;
            vblank_reg      <= 1'b0;
            oam_byte_reg    <= '0;
            read_buffer_reg <= '0;
            vram_reg        <= '0;
            temp_reg        <= '0;
            toggle_reg      <= 1'b0;
            dot_reg         <= '0;
            line_reg        <= '0;
            nmi_reg         <= 1'b0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            clearing_reg    <= clearing_next;
            clr_cnt_reg     <= clr_cnt_next;
            ctrl_nmi_reg    <= ctrl_nmi_next;
            ctrl_inc32_reg  <= ctrl_inc32_next;
            vblank_reg      <= vblank_next;
            oam_byte_reg    <= oam_byte_next;
            read_buffer_reg <= read_buffer_next;
            vram_reg        <= vram_next;
            temp_reg        <= temp_next;
            toggle_reg      <= toggle_next;
            dot_reg         <= dot_next;
            line_reg        <= line_next;
            nmi_reg         <= nmi_next;
            pend_reg        <= pend_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_src_reg <= pend_src_next;
        pend_pat_reg <= pend_pat_next;
        out_reg      <= out_next;
        skid_reg     <= skid_next;
    end

    vurf_ram #(
        .WIDTH (8),
        .DEPTH (NAMETABLE_BYTES)
    ) u_name_ram (
        .clk   (clk),
        .we    (nt_we),
        .waddr (nt_waddr),
        .wdata (ram_wdata),
        .raddr (nt_idx),
        .rdata (nt_rdata)
    );

    vurf_ram #(
        .WIDTH (8),
        .DEPTH (PALETTE_BYTES)
    ) u_pal_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (ram_wdata),
        .raddr (vram_reg[PAL_AW-1:0]),
        .rdata (pal_rdata)
    );

`ifndef NO_ASSERTIONS
    // No item may enter while the RAMs are still being cleared.
    a_no_intake_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !req.ready)
        else $error("item accepted during clearing sweep");

    // The skid entry is only ever occupied behind a full result register.
    a_skid_behind_result: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the result register is empty");

    // An NMI is latched only by a tick.
    a_nmi_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(nmi_reg) |-> $past(req.valid && req.ready && req.item.action == ACT_TICK))
        else $error("NMI latched by something other than a tick");

    // A buffer refill is in flight only right after an accepted data read.
    a_refill_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(req.valid && req.ready && req.item.action == ACT_READ
                           && req.item.cpu_addr[2:0] == REG_DATA))
        else $error("buffer refill without a data read");
`endif

endmodule

>>> design/vurf_ram.sv
// Single-port-write, single-port-read RAM with a registered read.
module vurf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sim/vurf_result_checker.sv
module vurf_result_checker
    import vurf_pkg::*;
#(
    parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_DEF,
    parameter int DOTS_PER_LINE   = DOTS_PER_LINE_DEF,
    parameter int LINES_PER_FRAME = LINES_PER_FRAME_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    vurf_in_if          req,
    vurf_out_if         rsp,
    output int unsigned fail_count,
    output int unsigned checked_count,
    output int unsigned results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] CPU_WINDOW_LO = 16'h2000;
    localparam logic [15:0] CPU_WINDOW_HI = 16'h3FFF;

    // Shadow copy of the register file state.
    logic [7:0]  ctrl_shadow;
    logic [7:0]  status_shadow;
    logic [7:0]  oam_shadow;
    logic [7:0]  read_buf_shadow;
    logic [15:0] vaddr_shadow;
    logic [15:0] taddr_shadow;
    logic        toggle_shadow;
    logic        nmi_shadow;
    int unsigned dot_shadow;
    int unsigned line_shadow;
    logic [7:0]  name_shadow [NAMETABLE_BYTES];
    logic [7:0]  pal_shadow [PALETTE_BYTES];

    out_item_t   awaited_results [$];
    out_item_t   oldest;

    function automatic logic [7:0] vram_fetch_byte(logic [VADDR_W-1:0] a, logic [7:0] pat);
        if (a < NAME_BASE)
            return pat;
        if (a <= NAME_LAST)
            return name_shadow[a % NAMETABLE_BYTES];
        return pal_shadow[a[PAL_AW-1:0]];
    endfunction

    // Applies one item to the shadow state and returns the result it causes.
    function automatic out_item_t step_register_file(in_item_t it);
        out_item_t           r;
        logic [VADDR_W-1:0]  va;
        logic [15:0]         stride;
        logic                in_window;
        r         = '0;
        va        = vaddr_shadow[VADDR_W-1:0];
        stride    = ctrl_shadow[2] ? 16'(STEP_ACROSS) : 16'(STEP_DOWN);
        in_window = (it.cpu_addr >= CPU_WINDOW_LO) && (it.cpu_addr <= CPU_WINDOW_HI);
        case (it.action)
            ACT_TICK: begin
                dot_shadow++;
                if (dot_shadow >= DOTS_PER_LINE) begin
                    dot_shadow = 0;
                    line_shadow++;
                end
                if (line_shadow == VBLANK_LINE && dot_shadow == 1) begin
                    status_shadow[7] = 1'b1;
                    if (ctrl_shadow[7])
                        nmi_shadow = 1'b1;
                end
                if (line_shadow == PRERENDER_LINE && dot_shadow == 1)
                    status_shadow[7] = 1'b0;
                if (line_shadow >= LINES_PER_FRAME)
                    line_shadow = 0;
            end
            ACT_READ: begin
                if (in_window) begin
                    case (reg_sel_t'(it.cpu_addr[2:0]))
                        REG_STATUS: begin
                            r.read_data      = status_shadow;
                            status_shadow[7] = 1'b0;
                            toggle_shadow    = 1'b0;
                        end
                        REG_OAM_DATA: r.read_data = oam_shadow;
                        REG_DATA: begin
                            r.read_data     = read_buf_shadow;
                            read_buf_shadow = vram_fetch_byte(va, it.pattern_byte);
                            vaddr_shadow    = vaddr_shadow + stride;
                        end
                        default: ;
                    endcase
                end
            end
            ACT_WRITE: begin
                if (in_window) begin
                    case (reg_sel_t'(it.cpu_addr[2:0]))
                        REG_CTRL:     ctrl_shadow = it.write_data;
                        REG_OAM_DATA: oam_shadow  = it.write_data;
                        REG_SCROLL:   toggle_shadow = ~toggle_shadow;
                        REG_ADDR: begin
                            if (!toggle_shadow) begin
                                taddr_shadow = {2'b00, it.write_data[5:0], taddr_shadow[7:0]};
                            end else begin
                                taddr_shadow[7:0] = it.write_data;
                                vaddr_shadow      = taddr_shadow;
                            end
                            toggle_shadow = ~toggle_shadow;
                        end
                        REG_DATA: begin
                            if (va >= NAME_BASE && va <= NAME_LAST)
                                name_shadow[va % NAMETABLE_BYTES] = it.write_data;
                            else if (va > NAME_LAST)
                                pal_shadow[va[PAL_AW-1:0]] = it.write_data;
                            vaddr_shadow = vaddr_shadow + stride;
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                r.nmi_taken = nmi_shadow;
                nmi_shadow  = 1'b0;
            end
        endcase
        r.nmi_pending      = nmi_shadow;
        r.vram_access_addr = vaddr_shadow[VADDR_W-1:0];
        r.in_vblank        = status_shadow[7];
        return r;
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // Results are compared before the item of the same edge is predicted, since
    // a result can never leave in the cycle its item is taken.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ctrl_shadow     <= '0;
            status_shadow   <= '0;
            oam_shadow      <= '0;
            read_buf_shadow <= '0;
            vaddr_shadow    <= '0;
            taddr_shadow    <= '0;
            toggle_shadow   <= 1'b0;
            nmi_shadow      <= 1'b0;
            dot_shadow      <= 0;
            line_shadow     <= 0;
            for (int i = 0; i < NAMETABLE_BYTES; i++)
                name_shadow[i] <= '0;
            for (int i = 0; i < PALETTE_BYTES; i++)
                pal_shadow[i] <= '0;
            awaited_results.delete();
            fail_count    <= 0;
            checked_count <= 0;
            results_owed  <= 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result mismatch, expected nothing, actual %h",
                             $time, rsp.item);
                end else begin
                    oldest = awaited_results.pop_front();
                    checked_count++;
                    check_field("read_data", 16'(oldest.read_data), 16'(rsp.item.read_data));
                    check_field("nmi_taken", 16'(oldest.nmi_taken), 16'(rsp.item.nmi_taken));
                    check_field("nmi_pending", 16'(oldest.nmi_pending),
                                16'(rsp.item.nmi_pending));
                    check_field("vram_access_addr", 16'(oldest.vram_access_addr),
                                16'(rsp.item.vram_access_addr));
                    check_field("in_vblank", 16'(oldest.in_vblank), 16'(rsp.item.in_vblank));
                end
            end
            if (req.valid && req.ready)
                awaited_results.push_back(step_register_file(req.item));
            results_owed <= awaited_results.size();
        end
    end

endmodule

>>> sim/tb_video_unit_register_file.sv
module tb_video_unit_register_file
    import vurf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // The block runs at its default sizes, so the checker shares them.
    localparam int          DOTS        = DOTS_PER_LINE_DEF;
    localparam int          LINES       = LINES_PER_FRAME_DEF;
    localparam int unsigned FRAME_TICKS = DOTS * LINES;

    localparam int RESET_CYCLES  = 5;
    localparam int TAIL_CYCLES   = 16;
    localparam int PHASE_ITEMS   = 190;

    // The slowest expected run is the clearing sweep after reset plus roughly
    // two frames of ticks, slowed further when the sink stalls half the time.
    // The limit leaves a wide margin on top of that.
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    // Idle and stall rates, in percent, for the four traffic phases: free
    // running, a sluggish source, a sluggish sink, and both at once.
    localparam int SEND_IDLE  [4] = '{0, 52, 0, 26};
    localparam int SINK_STALL [4] = '{0, 0, 52, 26};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        src_valid = 1'b0;
    in_item_t    src_item = '0;
    logic        sink_ready = 1'b0;

    int          send_idle_pct  = 0;
    int          sink_stall_pct = 0;
    int unsigned items_sent     = 0;
    int unsigned ticks_sent     = 0;
    int unsigned cycle_count    = 0;

    int unsigned fail_count;
    int unsigned checked_count;
    int unsigned results_owed;

    vurf_in_if  req_ch ();
    vurf_out_if rsp_ch ();

    assign req_ch.valid = src_valid;
    assign req_ch.item  = src_item;
    assign rsp_ch.ready = sink_ready;

    video_unit_register_file u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    vurf_result_checker #(
        .NAMETABLE_BYTES (NAMETABLE_BYTES_DEF),
        .DOTS_PER_LINE   (DOTS),
        .LINES_PER_FRAME (LINES)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .checked_count (checked_count),
        .results_owed  (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The sink side draws a fresh ready decision every cycle at the rate of
    // the current phase.
    always @(posedge clk)
    begin
        sink_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // A hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, results_owed);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Registers repeat every eight bytes across the CPU window, so each access
    // picks a random mirror of the selected register.
    function automatic logic [15:0] reg_at(reg_sel_t sel);
        return {3'b001, 10'($urandom_range(0, 1023)), sel};
    endfunction

    // Offers one item and returns once it has been accepted. Before the item
    // the source may sit idle at the current phase's rate; valid is only
    // lowered for those idle cycles, never between back-to-back items.
    task automatic send(action_t act, logic [15:0] addr, logic [7:0] wd, logic [7:0] pb);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= '{action: act, cpu_addr: addr, write_data: wd, pattern_byte: pb};
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        if (act == ACT_TICK)
            ticks_sent++;
    endtask

    // Holds the source off until every result already owed has come back. The
    // first edge lets the checker's count include the item just accepted.
    task automatic wait_all_results();
        src_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Sends ticks until the frame position lands on a random dot of a random
    // line in the given range. The position is known exactly because every
    // tick since reset went through send, which counts it.
    task automatic run_ticks_to_line(int unsigned first_line, int unsigned last_line);
        int unsigned pos;
        int unsigned target;
        int unsigned count;
        pos    = ticks_sent % FRAME_TICKS;
        target = $urandom_range(first_line, last_line) * DOTS + $urandom_range(0, DOTS - 1);
        count  = (target + FRAME_TICKS - pos) % FRAME_TICKS;
        repeat (count)
            send(ACT_TICK, 16'($urandom), rand_byte(), rand_byte());
    endtask

    // A typical CPU access pattern: reset the toggle through a status read,
    // load the two halves of the VRAM address, maybe change the step size,
    // then stream data reads and writes. Some sequences are left broken on
    // purpose, skipping the status read or the second address write.
    task automatic run_vram_sequence();
        logic [7:0]  hi;
        logic [7:0]  lo;
        int unsigned accesses;
        case ($urandom_range(0, 3))
            0:       hi = 8'($urandom_range(0, 8'h1F));
            1:       hi = 8'($urandom_range(8'h20, 8'h3E));
            2:       hi = 8'h3F;
            default: hi = rand_byte();
        endcase
        // Low bytes near the top of a page push the address across the name
        // table to palette boundary and past the end of the 14-bit space.
        lo = ($urandom_range(0, 3) == 0) ? (8'hF0 | 8'($urandom_range(0, 15))) : rand_byte();
        if ($urandom_range(0, 3) != 0)
            send(ACT_READ, reg_at(REG_STATUS), rand_byte(), rand_byte());
        send(ACT_WRITE, reg_at(REG_ADDR), hi, rand_byte());
        if ($urandom_range(0, 9) != 0)
            send(ACT_WRITE, reg_at(REG_ADDR), lo, rand_byte());
        if ($urandom_range(0, 4) == 0)
            send(ACT_WRITE, reg_at(REG_CTRL), rand_byte(), rand_byte());
        accesses = $urandom_range(1, 8);
        repeat (accesses)
            send($urandom_range(0, 1) ? ACT_READ : ACT_WRITE, reg_at(REG_DATA),
                 rand_byte(), rand_byte());
    endtask

    // Mixed traffic: VRAM sequences on 45 percent of draws, the rest single items
    // of any action, with about one address in five drawn from the whole bus.
    task automatic run_random_traffic(int unsigned n);
        int unsigned start;
        action_t     act;
        logic [15:0] addr;
        start = items_sent;
        while (items_sent - start < n) begin
            if ($urandom_range(0, 99) < 45) begin
                run_vram_sequence();
            end else begin
                act  = action_t'($urandom_range(0, 3));
                addr = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : reg_at(reg_sel_t'($urandom_range(0, 7)));
                send(act, addr, rand_byte(), rand_byte());
            end
        end
    endtask

    // Short hand-picked opening that touches every register and the corner
    // cases of the address map before any random traffic.
    task automatic run_directed();
        // Status straight after reset reads as zero.
        send(ACT_READ, reg_at(REG_STATUS), 8'h00, 8'hFF);
        // Step of 32 and NMI enable, then point VRAM at the palette. Only the
        // low six bits of the first address byte survive.
        send(ACT_WRITE, reg_at(REG_CTRL), 8'h84, 8'h00);
        send(ACT_WRITE, 16'h3FFE, 8'hFF, 8'h00);
        send(ACT_WRITE, reg_at(REG_ADDR), 8'h00, 8'h00);
        send(ACT_WRITE, 16'h3FFF, 8'hA5, 8'h00);
        send(ACT_WRITE, reg_at(REG_CTRL), 8'h00, 8'h00);
        // Palette reads come through the buffer like any other data read.
        send(ACT_WRITE, reg_at(REG_ADDR), 8'h3F, 8'h00);
        send(ACT_WRITE, reg_at(REG_ADDR), 8'h00, 8'h00);
        send(ACT_READ, reg_at(REG_DATA), 8'h00, 8'h00);
        send(ACT_READ, reg_at(REG_DATA), 8'h00, 8'h00);
        // Pattern space: reads take the supplied byte, writes are dropped.
        send(ACT_WRITE, reg_at(REG_ADDR), 8'h00, 8'h00);
        send(ACT_WRITE, reg_at(REG_ADDR), 8'h10, 8'h00);
        send(ACT_READ, reg_at(REG_DATA), 8'h00, 8'h5A);
        send(ACT_READ, reg_at(REG_DATA), 8'h00, 8'hC3);
        send(ACT_WRITE, reg_at(REG_DATA), 8'h77, 8'h00);
        // Accesses outside the CPU window do nothing at all.
        send(ACT_READ, 16'h1FFF, 8'h00, 8'hFF);
        send(ACT_WRITE, 16'hFFFF, 8'h12, 8'hFF);
        // A scroll write flips the shared toggle, so the next address write
        // lands in the low byte.
        send(ACT_WRITE, reg_at(REG_SCROLL), 8'h11, 8'h00);
        send(ACT_WRITE, reg_at(REG_ADDR), 8'hAB, 8'h00);
        // OAM data reads back; write-only registers read as zero.
        send(ACT_WRITE, reg_at(REG_OAM_DATA), 8'h3C, 8'h00);
        send(ACT_READ, reg_at(REG_OAM_DATA), 8'h00, 8'h00);
        send(ACT_WRITE, reg_at(REG_MASK), 8'hFF, 8'h00);
        send(ACT_WRITE, reg_at(REG_OAM_ADDR), 8'hFF, 8'h00);
        send(ACT_READ, reg_at(REG_MASK), 8'h00, 8'hFF);
        // Status writes are ignored, and an acknowledge with nothing pending
        // reports nothing taken.
        send(ACT_WRITE, reg_at(REG_STATUS), 8'hFF, 8'h00);
        send(ACT_NMI_ACK, 16'h0000, 8'h00, 8'h00);
        send(ACT_TICK, 16'hFFFF, 8'hFF, 8'hFF);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // The block clears its memories after reset and holds ready low until
        // done; the handshake in send absorbs that wait.
        run_directed();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = SEND_IDLE[ph];
            sink_stall_pct <= SINK_STALL[ph];

            // Let the pipeline empty completely before the new phase starts.
            wait_all_results();
            run_random_traffic(PHASE_ITEMS / 2);

            if (ph % 2 == 0) begin
                // Arm the NMI, then tick into the middle of vertical blank so
                // the flag rises and the latch fires on the way.
                send(ACT_WRITE, reg_at(REG_CTRL), {1'b1, 7'($urandom)}, rand_byte());
                run_ticks_to_line(VBLANK_LINE + 1, PRERENDER_LINE - 1);
                // First acknowledge takes the NMI, the second finds none.
                send(ACT_NMI_ACK, 16'($urandom), rand_byte(), rand_byte());
                send(ACT_NMI_ACK, 16'($urandom), rand_byte(), rand_byte());
                // Enabling NMI while already in vertical blank must not latch.
                send(ACT_WRITE, reg_at(REG_CTRL), {1'b1, 7'($urandom)}, rand_byte());
                send(ACT_NMI_ACK, 16'($urandom), rand_byte(), rand_byte());
                // Reading status reports vblank once, then clears it.
                send(ACT_READ, reg_at(REG_STATUS), rand_byte(), rand_byte());
                send(ACT_READ, reg_at(REG_STATUS), rand_byte(), rand_byte());
            end else begin
                // Tick past the pre-render line and the frame wrap into the
                // first lines of the next frame.
                run_ticks_to_line(0, 3);
            end

            run_random_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
        end

        // Drain, then give any stray result time to show up.
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d items (%0d dot ticks) over four idle and stall phases;",
                 items_sent, ticks_sent);
        $display("compared %0d results, with frame crossings into and out of vblank.",
                 checked_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
